@@ design/ucdw_pkg.sv @@
package ucdw_pkg;

  // walker phase
  typedef enum logic [1:0] {
    PH_IDLE,
    PH_HEADER,
    PH_BODY,
    PH_DONE
  } phase_t;

  // result kind codes as seen on the kind port
  typedef enum logic [2:0] {
    KIND_IFACE = 3'd0,
    KIND_EP    = 3'd1,
    KIND_OTHER = 3'd2,
    KIND_END   = 3'd3,
    KIND_ERR   = 3'd4
  } kind_t;

  // configuration register indexes
  localparam logic [7:0] CFG_MATCH_INTERFACE = 8'd0;
  localparam logic [7:0] CFG_MATCH_ALT       = 8'd1;

  localparam logic [7:0] TYPE_IFACE   = 8'd4;
  localparam logic [7:0] TYPE_EP      = 8'd5;
  localparam logic [7:0] ANY_IFACE    = 8'hFF;
  localparam logic [7:0] ORD_MAX      = 8'hFF;
  localparam logic [7:0] HDR_MIN_LEN  = 8'd4;
  localparam logic [7:0] DESC_MIN_LEN = 8'd2;

  // result queue
  localparam int QUEUE_DEPTH = 4;
  localparam int LEVEL_W     = 3;

  typedef struct packed {
    kind_t       kind;
    logic [15:0] offset;
    logic [7:0]  dtype;
    logic        sel;
    logic [7:0]  ordinal;
    logic        last;
  } ucdw_result_t;

  // up to two results from one byte, pushed in the same cycle
  typedef struct packed {
    logic [1:0]   count;
    ucdw_result_t first;
    ucdw_result_t second;
  } ucdw_push_t;

endpackage

@@ design/ucdw_core.sv @@
module ucdw_core import ucdw_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         fire,
  input  logic [7:0]   data_byte,
  input  logic         frame_start,
  input  logic [7:0]   match_interface,
  input  logic [7:0]   match_alt_setting,
  output ucdw_push_t   push
);

  phase_t      phase, phase_next, e_phase;
  logic [15:0] byte_offset, byte_offset_next, e_off;
  logic [15:0] total_length, total_length_next, e_total;
  logic [7:0]  header_length, header_length_next;
  logic [7:0]  pos_in_descriptor, pos_next, e_pos;
  logic [7:0]  current_length, current_length_next, e_clen;
  logic [7:0]  current_type, current_type_next, e_ctype;
  logic [15:0] current_start, current_start_next, e_cstart;
  logic [7:0]  iface_number, iface_number_next;
  logic [7:0]  iface_alt, iface_alt_next;
  logic        iface_seen, iface_seen_next;
  logic [7:0]  kind_counts [3];
  logic [7:0]  kind_counts_next [3];
  logic        active;
  kind_t       dkind;
  logic [1:0]  kidx;
  logic        dsel;
  ucdw_result_t r0, r1;
  logic [1:0]  nres;

  always_comb begin
    // frame start wipes the walk state before this byte is used
    e_phase  = frame_start ? PH_HEADER : phase;
    e_off    = frame_start ? '0 : byte_offset;
    e_total  = frame_start ? '0 : total_length;
    e_pos    = frame_start ? '0 : pos_in_descriptor;
    e_clen   = frame_start ? '0 : current_length;
    e_ctype  = frame_start ? '0 : current_type;
    e_cstart = frame_start ? '0 : current_start;
    active   = frame_start || (phase == PH_HEADER) || (phase == PH_BODY);

    phase_next          = e_phase;
    byte_offset_next    = e_off;
    total_length_next   = e_total;
    header_length_next  = frame_start ? '0 : header_length;
    pos_next            = e_pos;
    current_length_next = e_clen;
    current_type_next   = e_ctype;
    current_start_next  = e_cstart;
    iface_number_next   = frame_start ? '0 : iface_number;
    iface_alt_next      = frame_start ? '0 : iface_alt;
    iface_seen_next     = frame_start ? 1'b0 : iface_seen;
    for (int k = 0; k < 3; k++) begin
      kind_counts_next[k] = frame_start ? '0 : kind_counts[k];
    end

    r0    = '0;
    r1    = '0;
    nres  = 2'd0;
    dkind = KIND_OTHER;
    kidx  = 2'd0;
    dsel  = 1'b0;

    if (active) begin
      byte_offset_next = e_off + 16'd1;
      if (e_phase == PH_HEADER) begin
        if (e_off == 16'd0) begin
          header_length_next = data_byte;
          if (data_byte < HDR_MIN_LEN) begin
            r0.kind    = KIND_ERR;
            nres       = 2'd1;
            phase_next = PH_DONE;
          end
        end else if (e_off == 16'd1) begin
          current_type_next = data_byte;
        end else if (e_off == 16'd2) begin
          total_length_next = {e_total[15:8], data_byte};
        end else if (e_off == 16'd3) begin
          total_length_next = {data_byte, e_total[7:0]};
        end
        if (phase_next == PH_HEADER &&
            ({1'b0, e_off} + 17'd1) == {9'd0, header_length_next}) begin
          if (total_length_next < {8'd0, header_length_next}) begin
            r0.kind  = KIND_ERR;
            r0.dtype = current_type_next;
            nres       = 2'd1;
            phase_next = PH_DONE;
          end else if (total_length_next == {8'd0, header_length_next}) begin
            r0.kind   = KIND_END;
            r0.offset = total_length_next;
            nres       = 2'd1;
            phase_next = PH_DONE;
          end else begin
            phase_next = PH_BODY;
            pos_next   = '0;
          end
        end
      end else begin
        if (e_pos == 8'd0) begin
          current_start_next  = e_off;
          current_length_next = data_byte;
          current_type_next   = '0;
          if (data_byte < DESC_MIN_LEN ||
              ({1'b0, e_off} + {9'd0, data_byte}) > {1'b0, e_total}) begin
            r0.kind    = KIND_ERR;
            r0.offset  = e_off;
            nres       = 2'd1;
            phase_next = PH_DONE;
          end else begin
            pos_next = 8'd1;
          end
        end else begin
          if (e_pos == 8'd1) begin
            current_type_next = data_byte;
            if (data_byte == TYPE_IFACE) begin
              iface_seen_next   = 1'b1;
              iface_number_next = '0;
              iface_alt_next    = '0;
            end
          end else if (e_ctype == TYPE_IFACE) begin
            if (e_pos == 8'd2) begin
              iface_number_next = data_byte;
            end else if (e_pos == 8'd3) begin
              iface_alt_next = data_byte;
            end
          end
          pos_next = e_pos + 8'd1;
          if (pos_next == e_clen) begin
            if (current_type_next == TYPE_IFACE) begin
              dkind = KIND_IFACE;
            end else if (current_type_next == TYPE_EP) begin
              dkind = KIND_EP;
              dsel  = iface_seen_next &&
                      (match_interface == ANY_IFACE ||
                       match_interface == iface_number_next) &&
                      (match_alt_setting == iface_alt_next);
            end else begin
              dkind = KIND_OTHER;
            end
            kidx       = dkind[1:0];
            r0.kind    = dkind;
            r0.offset  = e_cstart;
            r0.dtype   = current_type_next;
            r0.sel     = dsel;
            r0.ordinal = kind_counts_next[kidx];
            nres       = 2'd1;
            if (kind_counts_next[kidx] != ORD_MAX) begin
              kind_counts_next[kidx] = kind_counts_next[kidx] + 8'd1;
            end
            pos_next = '0;
            if (byte_offset_next == e_total) begin
              r1.kind    = KIND_END;
              r1.offset  = e_total;
              nres       = 2'd2;
              phase_next = PH_DONE;
            end
          end
        end
      end
    end

    r0.last = (nres == 2'd1);
    r1.last = 1'b1;
    push.count  = fire ? nres : 2'd0;
    push.first  = r0;
    push.second = r1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_IDLE;
      byte_offset       <= '0;
      total_length      <= '0;
      header_length     <= '0;
      pos_in_descriptor <= '0;
      current_length    <= '0;
      current_type      <= '0;
      current_start     <= '0;
      iface_number      <= '0;
      iface_alt         <= '0;
      iface_seen        <= 1'b0;
      for (int k = 0; k < 3; k++) begin
        kind_counts[k] <= '0;
      end
    end else if (fire) begin
      phase             <= phase_next;
      byte_offset       <= byte_offset_next;
      total_length      <= total_length_next;
      header_length     <= header_length_next;
      pos_in_descriptor <= pos_next;
      current_length    <= current_length_next;
      current_type      <= current_type_next;
      current_start     <= current_start_next;
      iface_number      <= iface_number_next;
      iface_alt         <= iface_alt_next;
      iface_seen        <= iface_seen_next;
      for (int k = 0; k < 3; k++) begin
        kind_counts[k] <= kind_counts_next[k];
      end
    end
  end

`ifndef SYNTHESIS
  // a pair of results is always a descriptor followed by end of list
  a_pair_order: assert property (@(posedge clk) disable iff (rst)
    push.count == 2'd2 |->
      (push.first.kind != KIND_END && push.first.kind != KIND_ERR &&
       push.second.kind == KIND_END))
    else $error("result pair out of order");

  // once done, only a frame start leaves the done phase
  a_done_holds: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_DONE && !(fire && frame_start)) |=> phase == PH_DONE)
    else $error("left done phase without frame start");
`endif

endmodule

@@ design/ucdw_queue.sv @@
module ucdw_queue import ucdw_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  ucdw_push_t         push,
  input  logic               pop_ready,
  output ucdw_result_t       head,
  output logic               valid,
  output logic [LEVEL_W-1:0] level
);

  ucdw_result_t       entries [QUEUE_DEPTH];
  ucdw_result_t       entries_next [QUEUE_DEPTH];
  logic [LEVEL_W-1:0] level_next;
  logic [LEVEL_W-1:0] base;
  logic               pop;

  assign valid = (level != '0);
  assign head  = entries[0];
  assign pop   = valid && pop_ready;

  // head sits at entry 0; a pop shifts everything down one place
  always_comb begin
    base = level - {{(LEVEL_W-1){1'b0}}, pop};
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      if (pop && i < QUEUE_DEPTH - 1) begin
        entries_next[i] = entries[(i + 1) % QUEUE_DEPTH];
      end else begin
        entries_next[i] = entries[i];
      end
      if (push.count != 2'd0 && LEVEL_W'(i) == base) begin
        entries_next[i] = push.first;
      end
      if (push.count == 2'd2 && LEVEL_W'(i) == base + LEVEL_W'(1)) begin
        entries_next[i] = push.second;
      end
    end
    level_next = base + {{(LEVEL_W-2){1'b0}}, push.count};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      level <= '0;
    end else begin
      level <= level_next;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      entries[i] <= entries_next[i];
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    level <= LEVEL_W'(QUEUE_DEPTH))
    else $error("result queue overflow");

  a_push_shows: assert property (@(posedge clk) disable iff (rst)
    push.count != 2'd0 |=> valid)
    else $error("pushed result not presented");
`endif

endmodule

@@ design/usb_config_descriptor_walker.sv @@
// Channel | Direction | Signals                            | Beat
// in      | sink      | in_valid/in_ready                  | data_byte, frame_start
// out     | source    | out_valid/out_ready                | kind, descriptor_offset,
//         |           |                                    | descriptor_type,
//         |           |                                    | endpoint_selected, ordinal, last
// cfg     | sink      | cfg_valid/cfg_ready (always ready) | cfg_index, cfg_data
//
// One byte beat per cycle while the queue has room for a pair; the held beat is walked
// and its results registered into a four-entry queue. A two-result byte takes two output
// beats, absorbed by the queue; the input register stalls with fewer than two slots free.
// Synchronous reset: phase idle, queue empty, filter any interface / alt 0.
// out_ready only reaches in_ready through the registered queue fill level.
module usb_config_descriptor_walker import ucdw_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        frame_start,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  kind,
  output logic [15:0] descriptor_offset,
  output logic [7:0]  descriptor_type,
  output logic        endpoint_selected,
  output logic [7:0]  ordinal,
  output logic        last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  // filter registers
  logic [7:0] match_interface;
  logic [7:0] match_alt_setting;

  // input register
  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_frame_start;
  logic       s1_fire;

  ucdw_push_t         push;
  ucdw_result_t       head;
  logic [LEVEL_W-1:0] level;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      match_interface   <= ANY_IFACE;
      match_alt_setting <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_MATCH_INTERFACE: match_interface   <= cfg_data;
        CFG_MATCH_ALT:       match_alt_setting <= cfg_data;
        default: ;
      endcase
    end
  end

  // walk the held byte only when the queue can take a full pair
  assign s1_fire  = s1_valid && (level <= LEVEL_W'(QUEUE_DEPTH - 2));
  assign in_ready = !s1_valid || s1_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte        <= data_byte;
      s1_frame_start <= frame_start;
    end
  end

  ucdw_core u_core (
    .clk               (clk),
    .rst               (rst),
    .fire              (s1_fire),
    .data_byte         (s1_byte),
    .frame_start       (s1_frame_start),
    .match_interface   (match_interface),
    .match_alt_setting (match_alt_setting),
    .push              (push)
  );

  ucdw_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .pop_ready (out_ready),
    .head      (head),
    .valid     (out_valid),
    .level     (level)
  );

  assign kind              = head.kind;
  assign descriptor_offset = head.offset;
  assign descriptor_type   = head.dtype;
  assign endpoint_selected = head.sel;
  assign ordinal           = head.ordinal;
  assign last              = head.last;

endmodule
